[hdl/baro_pressure_temp_compensation_macros.svh]
// Assertion macros for the barometric compensation block.
// Used by the top level only; no other dependencies.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

`ifndef SYNTH
`define BPTC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPTC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPTC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BPTC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

[hdl/bptc_pkg.sv]
// Shared types and constants for the barometric compensation block.
// No dependencies.
`timescale 1ns / 1ps

package bptc_pkg;

    localparam int DIV_W = 64;

    typedef enum logic [1:0] {
        CFG_TEMP_TRIM  = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_PRESS_LAST = 2'd3
    } cfg_idx_t;

    localparam logic [20:0]        RAW_FULL    = 21'd1048576;
    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic [11:0]        PRESS_SCALE = 12'd3125;
    localparam logic [63:0]        PRESS_BIAS  = 64'h0000_8000_0000_0000;

    // side data that rides along with the divider
    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic        neg;
        logic        dz;
    } bptc_side_t;

endpackage

[hdl/bptc_div.sv]
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
// Depends on bptc_pkg.
`timescale 1ns / 1ps

module bptc_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [63:0]          in_num,
    input  logic [63:0]          in_den,
    input  bptc_pkg::bptc_side_t in_side,
    output logic                 out_valid,
    output logic [63:0]          out_quo,
    output bptc_pkg::bptc_side_t out_side
);
    import bptc_pkg::*;

    logic [DIV_W-1:0] rem_reg  [DIV_W];
    logic [DIV_W-1:0] quo_reg  [DIV_W];
    logic [DIV_W-1:0] den_reg  [DIV_W];
    bptc_side_t       side_reg [DIV_W];
    logic [DIV_W-1:0] vld_reg;

    genvar g;
    generate
        for (g = 0; g < DIV_W; g++) begin : g_stage
            logic [DIV_W-1:0] r_in, q_in, d_in;
            bptc_side_t       s_in;
            logic             v_in;
            logic [DIV_W:0]   shifted;
            logic [DIV_W:0]   trial;

            if (g == 0) begin : g_first
                assign r_in = '0;
                assign q_in = in_num;
                assign d_in = in_den;
                assign s_in = in_side;
                assign v_in = in_valid;
            end else begin : g_rest
                assign r_in = rem_reg[g-1];
                assign q_in = quo_reg[g-1];
                assign d_in = den_reg[g-1];
                assign s_in = side_reg[g-1];
                assign v_in = vld_reg[g-1];
            end

            assign shifted = {r_in, q_in[DIV_W-1]};
            assign trial   = shifted - {1'b0, d_in};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (en) begin
                    vld_reg[g] <= v_in;
                end
            end

            // negative trial means the divisor did not fit: keep the shifted remainder
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g]  <= trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
                    quo_reg[g]  <= {q_in[DIV_W-2:0], ~trial[DIV_W]};
                    den_reg[g]  <= d_in;
                    side_reg[g] <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[DIV_W-1];
    assign out_quo   = quo_reg[DIV_W-1];
    assign out_side  = side_reg[DIV_W-1];

endmodule

[hdl/baro_pressure_temp_compensation.sv]
// Path from an accepted item to its result on m_tdata/m_tuser:
// 14 front stages, 64 divider stages, 7 back stages, output register.
// Throughput: one item per cycle, but a full skid entry freezes the whole pipeline
// until the output drains; the 64-stage quotient pipeline sets the depth.
// Reset (aresetn low, synchronous) clears all valid bits and the trim registers.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_macros.svh"

module baro_pressure_temp_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // temp_centi, fine_temp, pressure_q24_8
    output logic [95:0] m_tdata,
    // div_zero
    output logic        m_tuser
);
    import bptc_pkg::*;

    // trim registers
    logic [47:0] temp_trim_reg;
    logic [63:0] press_trim_low_reg, press_trim_high_reg;
    logic [15:0] press_trim_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_trim_reg       <= '0;
            press_trim_low_reg  <= '0;
            press_trim_high_reg <= '0;
            press_trim_last_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_TEMP_TRIM:  temp_trim_reg       <= cfg_wdata[47:0];
                CFG_PRESS_LOW:  press_trim_low_reg  <= cfg_wdata;
                CFG_PRESS_HIGH: press_trim_high_reg <= cfg_wdata;
                CFG_PRESS_LAST: press_trim_last_reg <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = temp_trim_reg[15:0];
    assign t2 = $signed(temp_trim_reg[31:16]);
    assign t3 = $signed(temp_trim_reg[47:32]);
    assign p1 = press_trim_low_reg[15:0];
    assign p2 = $signed(press_trim_low_reg[31:16]);
    assign p3 = $signed(press_trim_low_reg[47:32]);
    assign p4 = $signed(press_trim_low_reg[63:48]);
    assign p5 = $signed(press_trim_high_reg[15:0]);
    assign p6 = $signed(press_trim_high_reg[31:16]);
    assign p7 = $signed(press_trim_high_reg[47:32]);
    assign p8 = $signed(press_trim_high_reg[63:48]);
    assign p9 = $signed(press_trim_last_reg);

    // flow control
    logic en, s_accept;
    logic sk_valid_reg, m_valid_reg;
    assign en       = ~sk_valid_reg;
    assign s_tready = en;
    assign s_accept = s_tvalid & en;

    logic [13:0] fv_reg;
    logic [6:0]  bv_reg;
    logic        div_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
            bv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[12:0], s_accept};
            bv_reg <= {bv_reg[5:0], div_vld};
        end
    end

    // ---------------- front: temperature and pressure operands ----------------
    logic [19:0]        rp_raw, rt_raw;
    assign rp_raw = {s_tdata[7:0],   s_tdata[15:8],  s_tdata[23:20]};
    assign rt_raw = {s_tdata[31:24], s_tdata[39:32], s_tdata[47:44]};

    logic [19:0]        rp1_reg, rp2_reg, rp3_reg, rp4_reg, rp5_reg, rp6_reg;
    logic [19:0]        rp7_reg, rp8_reg, rp9_reg, rp10_reg;
    logic signed [17:0] a1_reg;
    logic signed [16:0] b1_reg;
    logic signed [33:0] at2_reg, bb2_reg;
    logic signed [22:0] v1t3_reg, v1t4_reg;
    logic [21:0]        bbs3_reg;
    logic signed [38:0] bt4_reg;
    logic signed [31:0] fine5_reg;
    logic signed [35:0] centi_next;
    logic signed [32:0] pv6_reg;
    logic signed [65:0] sq_next;
    logic signed [48:0] m5_next, m2_next;
    logic [63:0]        sq7_reg, m5_7_reg, m2_7_reg, m5_8_reg, m2_8_reg, m5_9_reg, m2_9_reg;
    logic signed [48:0] p6lo8_reg, p3lo8_reg;
    logic [31:0]        p6hi8_reg, p3hi8_reg;
    logic [63:0]        x6_9_reg, x3_9_reg, v2_10_reg, v1p10_reg;
    logic [63:0]        w11_reg, num11_reg;
    logic [20:0]        pp_next;
    logic [47:0]        wlo12_reg;
    logic [43:0]        nlo12_reg;
    logic [31:0]        whi12_reg, nhi12_reg;
    logic [63:0]        den13_reg, num13_reg;
    logic [63:0]        dval_next;
    logic [63:0]        ma14_reg, mb14_reg;
    bptc_side_t         side6_reg, side7_reg, side8_reg, side9_reg, side10_reg;
    bptc_side_t         side11_reg, side12_reg, side13_reg, side14_reg;

    assign centi_next = 36'(fine5_reg) * 36'sd5 + 36'sd128;
    assign sq_next    = pv6_reg * pv6_reg;
    assign m5_next    = pv6_reg * p5;
    assign m2_next    = pv6_reg * p2;
    assign pp_next    = RAW_FULL - {1'b0, rp10_reg};
    assign dval_next  = 64'($signed(den13_reg) >>> 33);

    always_ff @(posedge aclk) begin
        if (en) begin
            // S1: raw unpack and temperature differences
            rp1_reg  <= rp_raw;
            a1_reg   <= $signed({1'b0, rt_raw[19:3]}) - $signed({1'b0, t1, 1'b0});
            b1_reg   <= $signed({1'b0, rt_raw[19:4]}) - $signed({1'b0, t1});
            // S2
            rp2_reg  <= rp1_reg;
            at2_reg  <= a1_reg * t2;
            bb2_reg  <= b1_reg * b1_reg;
            // S3
            rp3_reg  <= rp2_reg;
            v1t3_reg <= 23'(at2_reg >>> 11);
            bbs3_reg <= bb2_reg[33:12];
            // S4
            rp4_reg  <= rp3_reg;
            v1t4_reg <= v1t3_reg;
            bt4_reg  <= $signed({1'b0, bbs3_reg}) * t3;
            // S5: fine temperature
            rp5_reg   <= rp4_reg;
            fine5_reg <= 32'(v1t4_reg) + 32'(bt4_reg >>> 14);
            // S6
            rp6_reg          <= rp5_reg;
            pv6_reg          <= 33'(fine5_reg) - FINE_OFFSET;
            side6_reg.centi  <= 32'(centi_next >>> 8);
            side6_reg.fine   <= fine5_reg;
            side6_reg.neg    <= 1'b0;
            side6_reg.dz     <= 1'b0;
            // S7
            rp7_reg   <= rp6_reg;
            side7_reg <= side6_reg;
            sq7_reg   <= 64'(sq_next);
            m5_7_reg  <= 64'(m5_next);
            m2_7_reg  <= 64'(m2_next);
            // S8: low 64 bits of sq*p6 and sq*p3 as two partial products each
            rp8_reg   <= rp7_reg;
            side8_reg <= side7_reg;
            m5_8_reg  <= m5_7_reg;
            m2_8_reg  <= m2_7_reg;
            p6lo8_reg <= $signed({1'b0, sq7_reg[31:0]}) * p6;
            p6hi8_reg <= 32'(sq7_reg[63:32] * 32'(p6));
            p3lo8_reg <= $signed({1'b0, sq7_reg[31:0]}) * p3;
            p3hi8_reg <= 32'(sq7_reg[63:32] * 32'(p3));
            // S9
            rp9_reg   <= rp8_reg;
            side9_reg <= side8_reg;
            m5_9_reg  <= m5_8_reg;
            m2_9_reg  <= m2_8_reg;
            x6_9_reg  <= 64'(p6lo8_reg) + {p6hi8_reg, 32'b0};
            x3_9_reg  <= 64'(p3lo8_reg) + {p3hi8_reg, 32'b0};
            // S10
            rp10_reg   <= rp9_reg;
            side10_reg <= side9_reg;
            v2_10_reg  <= x6_9_reg + (m5_9_reg << 17) + (64'(p4) << 35);
            v1p10_reg  <= 64'($signed(x3_9_reg) >>> 8) + (m2_9_reg << 12);
            // S11
            side11_reg <= side10_reg;
            w11_reg    <= v1p10_reg + PRESS_BIAS;
            num11_reg  <= ({43'b0, pp_next} << 31) - v2_10_reg;
            // S12
            side12_reg <= side11_reg;
            wlo12_reg  <= 48'(w11_reg[31:0]) * 48'(p1);
            whi12_reg  <= 32'(w11_reg[63:32] * {16'b0, p1});
            nlo12_reg  <= 44'(num11_reg[31:0]) * 44'(PRESS_SCALE);
            nhi12_reg  <= 32'(num11_reg[63:32] * 32'(PRESS_SCALE));
            // S13
            side13_reg <= side12_reg;
            den13_reg  <= 64'(wlo12_reg) + {whi12_reg, 32'b0};
            num13_reg  <= 64'(nlo12_reg) + {nhi12_reg, 32'b0};
            // S14: sign and magnitude for the divider
            side14_reg.centi <= side13_reg.centi;
            side14_reg.fine  <= side13_reg.fine;
            side14_reg.neg   <= num13_reg[63] ^ dval_next[63];
            side14_reg.dz    <= (dval_next == 64'd0);
            ma14_reg <= num13_reg[63] ? (64'd0 - num13_reg) : num13_reg;
            mb14_reg <= dval_next[63] ? (64'd0 - dval_next) : dval_next;
        end
    end

    // ---------------- divider ----------------
    logic [63:0] quo;
    bptc_side_t  div_side;

    bptc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fv_reg[13]),
        .in_num    (ma14_reg),
        .in_den    (mb14_reg),
        .in_side   (side14_reg),
        .out_valid (div_vld),
        .out_quo   (quo),
        .out_side  (div_side)
    );

    // ---------------- back: second-order corrections ----------------
    logic [63:0]        pd1_reg, pd2_reg, pd3_reg, pd4_reg, pd5_reg;
    logic [63:0]        sd1_reg, sd2_reg, sd3_reg;
    logic signed [48:0] p9lo2_reg, p8lo2_reg;
    logic [31:0]        p9hi2_reg, p8hi2_reg;
    logic [63:0]        t3_reg, m8_3_reg;
    logic [63:0]        ull4_reg, v2b4_reg, v2b5_reg, v1b5_reg;
    logic [31:0]        ulh4_reg, uhl4_reg;
    logic [63:0]        sum6_reg;
    logic [63:0]        pq_next;
    logic [31:0]        pres7_reg;
    bptc_side_t         sided1_reg, sided2_reg, sided3_reg, sided4_reg;
    bptc_side_t         sided5_reg, sided6_reg, sided7_reg;

    assign pq_next = div_side.neg ? (64'd0 - quo) : quo;

    always_ff @(posedge aclk) begin
        if (en) begin
            // D1: signed quotient
            sided1_reg <= div_side;
            pd1_reg    <= pq_next;
            sd1_reg    <= 64'($signed(pq_next) >>> 13);
            // D2: p9*s and p8*p, partial products
            sided2_reg <= sided1_reg;
            pd2_reg    <= pd1_reg;
            sd2_reg    <= sd1_reg;
            p9lo2_reg  <= $signed({1'b0, sd1_reg[31:0]}) * p9;
            p9hi2_reg  <= 32'(sd1_reg[63:32] * 32'(p9));
            p8lo2_reg  <= $signed({1'b0, pd1_reg[31:0]}) * p8;
            p8hi2_reg  <= 32'(pd1_reg[63:32] * 32'(p8));
            // D3
            sided3_reg <= sided2_reg;
            pd3_reg    <= pd2_reg;
            sd3_reg    <= sd2_reg;
            t3_reg     <= 64'(p9lo2_reg) + {p9hi2_reg, 32'b0};
            m8_3_reg   <= 64'(p8lo2_reg) + {p8hi2_reg, 32'b0};
            // D4: (p9*s)*s, low 64 bits
            sided4_reg <= sided3_reg;
            pd4_reg    <= pd3_reg;
            ull4_reg   <= 64'(t3_reg[31:0]) * 64'(sd3_reg[31:0]);
            ulh4_reg   <= 32'(t3_reg[31:0] * sd3_reg[63:32]);
            uhl4_reg   <= 32'(t3_reg[63:32] * sd3_reg[31:0]);
            v2b4_reg   <= 64'($signed(m8_3_reg) >>> 19);
            // D5
            sided5_reg <= sided4_reg;
            pd5_reg    <= pd4_reg;
            v2b5_reg   <= v2b4_reg;
            v1b5_reg   <= 64'($signed(ull4_reg + {ulh4_reg + uhl4_reg, 32'b0}) >>> 25);
            // D6
            sided6_reg <= sided5_reg;
            sum6_reg   <= pd5_reg + v1b5_reg + v2b5_reg;
            // D7
            sided7_reg <= sided6_reg;
            pres7_reg  <= sided6_reg.dz ? 32'd0
                        : 32'(64'($signed(sum6_reg) >>> 8) + (64'(p7) << 4));
        end
    end

    // ---------------- output register and skid entry ----------------
    logic [95:0] m_data_reg, sk_data_reg;
    logic        m_user_reg, sk_user_reg;
    logic        take;
    logic [95:0] last_data;

    assign take      = m_tready | ~m_valid_reg;
    assign last_data = {pres7_reg, sided7_reg.fine, sided7_reg.centi};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (sk_valid_reg) begin
            if (take) begin
                m_valid_reg  <= 1'b1;
                sk_valid_reg <= 1'b0;
            end
        end else if (take) begin
            m_valid_reg <= bv_reg[6];
        end else if (bv_reg[6]) begin
            sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (sk_valid_reg) begin
            if (take) begin
                m_data_reg <= sk_data_reg;
                m_user_reg <= sk_user_reg;
            end
        end else if (take) begin
            m_data_reg <= last_data;
            m_user_reg <= sided7_reg.dz;
        end else begin
            sk_data_reg <= last_data;
            sk_user_reg <= sided7_reg.dz;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `BPTC_ASSERT_IMP(a_skid_implies_out, aclk, aresetn, sk_valid_reg, m_valid_reg)
    `BPTC_ASSERT_IMP(a_dz_zero_press, aclk, aresetn, m_valid_reg && m_user_reg, m_data_reg[95:64] == 32'd0)
    `BPTC_ASSERT_NXT(a_skid_holds, aclk, aresetn, sk_valid_reg && !m_tready, sk_valid_reg && $stable(sk_data_reg))

endmodule

[test/baro_pressure_temp_compensation_tb.sv]
// Self-checking bench for baro_pressure_temp_compensation: trims are written over
// the cfg port, raw sensor bytes go in on s_*, compensated results are checked on m_*.
// Depends on bptc_pkg and the block RTL.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_tb;
    import bptc_pkg::*;

    localparam int LATENCY   = 86;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic [31:0] press;
        logic        dz;
    } comp_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;

    baro_pressure_temp_compensation u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // trim copy used by the predictor
    logic [47:0] temp_trim_q;
    logic [63:0] press_lo_q, press_hi_q;
    logic [15:0] press_last_q;

    logic [47:0] raw_q[$];
    comp_res_t   expected_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          dz_seen = 0;
    int          cycles = 0;
    bit          calm = 1'b0;   // no idling on either side
    bit          hold = 1'b0;   // sender paused
    bit          in_taken = 1'b0; // item on s_* accepted at the last rising edge

    function automatic logic signed [63:0] s16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic signed [63:0] sq_div(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic comp_res_t compensate(input logic [47:0] raw);
        logic signed [63:0] rp, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] a, b, v1, v2, fine, p;
        comp_res_t r;
        rp = {44'd0, raw[7:0], raw[15:8], raw[23:20]};
        rt = {44'd0, raw[31:24], raw[39:32], raw[47:44]};
        t1 = {48'd0, temp_trim_q[15:0]};
        t2 = s16(temp_trim_q[31:16]);
        t3 = s16(temp_trim_q[47:32]);
        p1 = {48'd0, press_lo_q[15:0]};
        p2 = s16(press_lo_q[31:16]);
        p3 = s16(press_lo_q[47:32]);
        p4 = s16(press_lo_q[63:48]);
        p5 = s16(press_hi_q[15:0]);
        p6 = s16(press_hi_q[31:16]);
        p7 = s16(press_hi_q[47:32]);
        p8 = s16(press_hi_q[63:48]);
        p9 = s16(press_last_q);
        a = (rt >>> 3) - (t1 <<< 1);
        v1 = (a * t2) >>> 11;
        b = (rt >>> 4) - t1;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        fine = v1 + v2;
        fine = {{32{fine[31]}}, fine[31:0]};
        r.fine = fine[31:0];
        a = (fine * 5 + 128) >>> 8;
        r.centi = a[31:0];
        v1 = fine - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0) begin
            r.dz = 1'b1;
            r.press = '0;
        end else begin
            r.dz = 1'b0;
            p = 64'sd1048576 - rp;
            p = sq_div(((p <<< 31) - v2) * 3125, v1);
            v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    // driver: a new item only once the current one has been accepted
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (raw_q.size() > 0 && !hold && (calm || $urandom_range(99) >= 20)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= raw_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || $urandom_range(99) >= 20;
        end
    end

    // prediction at acceptance, checking at result
    always @(posedge aclk) begin
        comp_res_t got, exp_r;
        cycles <= cycles + 1;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            expected_q.push_back(compensate(s_tdata));
            void'(raw_q.pop_front());
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
            results_seen++;
            if (got.dz) dz_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: centi %h/%h fine %h/%h press %h/%h dz %b/%b",
                                 exp_r.centi, got.centi, exp_r.fine, got.fine,
                                 exp_r.press, got.press, exp_r.dz, got.dz);
                end
            end
        end
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_trim(input cfg_idx_t idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_TEMP_TRIM:  temp_trim_q = val[47:0];
            CFG_PRESS_LOW:  press_lo_q = val;
            CFG_PRESS_HIGH: press_hi_q = val;
            default:        press_last_q = val[15:0];
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (raw_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [47:0] rand_raw();
        return 48'({$urandom, $urandom});
    endfunction

    initial begin
        temp_trim_q = '0;
        press_lo_q = '0;
        press_hi_q = '0;
        press_last_q = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero trims give a zero divisor
        raw_q.push_back('0);
        raw_q.push_back('1);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_trim(CFG_TEMP_TRIM, 64'({16'hFE0C, 16'd26435, 16'd27504}));
                    write_trim(CFG_PRESS_LOW, {16'd2855, 16'd3024, 16'hD6D0, 16'd36477});
                    write_trim(CFG_PRESS_HIGH, {16'hEC78, 16'd15500, 16'hFFF9, 16'd140});
                    write_trim(CFG_PRESS_LAST, 64'd6000);
                end
                1: begin
                    write_trim(CFG_TEMP_TRIM, 64'h0000_FFFF_FFFF_FFFF);
                    write_trim(CFG_PRESS_LOW, '1);
                    write_trim(CFG_PRESS_HIGH, '1);
                    write_trim(CFG_PRESS_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
                end
                2: begin
                    write_trim(CFG_TEMP_TRIM, 64'h0000_8000_7FFF_0000);
                    write_trim(CFG_PRESS_LOW, 64'h7FFF_8000_7FFF_FFFF);
                    write_trim(CFG_PRESS_HIGH, 64'h8000_7FFF_8000_7FFF);
                    write_trim(CFG_PRESS_LAST, 64'h8000);
                end
                3: begin
                    // P1 of zero forces the zero-divisor path
                    write_trim(CFG_PRESS_LOW, 64'h1234_5678_9ABC_0000);
                    write_trim(CFG_PRESS_LAST, 64'h7FFF);
                end
                default: begin
                    write_trim(CFG_TEMP_TRIM, {$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFF);
                    write_trim(CFG_PRESS_LOW, {$urandom, $urandom});
                    write_trim(CFG_PRESS_HIGH, {$urandom, $urandom});
                    write_trim(CFG_PRESS_LAST, {$urandom, $urandom});
                end
            endcase
            if (phase == 0) begin
                // field extremes and the ignored low nibbles
                raw_q.push_back(48'h0);
                raw_q.push_back(48'hFFFF_FFFF_FFFF);
                raw_q.push_back(48'h0F00_000F_0000);
                raw_q.push_back(48'hF0FF_FFF0_FFFF);
                raw_q.push_back(48'h8080_8080_8080);
                raw_q.push_back(48'h7F7F_7F7F_7F7F);
                raw_q.push_back(48'h0000_FF00_0000);
                raw_q.push_back(48'hFFFF_00FF_FFFF);
                for (int i = 0; i < 12; i++) raw_q.push_back(48'h1 << (4 * i));
            end
            calm = (phase == 1);
            for (int i = 0; i < 110; i++) begin
                if (phase != 1 && $urandom_range(3) != 0) begin
                    // plausible readings near room conditions
                    raw_q.push_back({4'($urandom), 4'(0), 8'($urandom_range(70, 140)),
                                     8'($urandom), 4'($urandom), 4'(0),
                                     8'($urandom_range(70, 110)), 8'($urandom)}
                                    | 48'($urandom_range(15)) << 20
                                    | 48'($urandom_range(15)) << 44);
                end else begin
                    raw_q.push_back(rand_raw());
                end
                // sender waits for the pipeline to empty once per phase
                if (i == 55) begin
                    while (raw_q.size() > 0 || s_tvalid) @(posedge aclk);
                    hold = 1'b1;
                    while (expected_q.size() > 0) @(posedge aclk);
                    hold = 1'b0;
                end
            end
            drain();
            calm = 1'b0;
        end

        $display("%0d results checked over 6 trim settings, %0d with zero divisor",
                 results_seen, dz_seen);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/bptc_pkg.sv
hdl/bptc_div.sv
hdl/baro_pressure_temp_compensation.sv
test/baro_pressure_temp_compensation_tb.sv
